@@ hdl/tdcp_pkg.sv @@
`timescale 1ns / 1ps

package tdcp_pkg;

    localparam int NUM_POS  = 12;
    localparam int IN_W     = 16;
    localparam int AXIS_W   = 8;
    localparam int SCORE_W  = 16;
    localparam int POS_W    = 4;
    localparam int BEST_W   = 14;
    localparam int GROUP_SZ = 4;
    localparam int NUM_GRP  = NUM_POS / GROUP_SZ;

    typedef logic signed [IN_W-1:0]    sample_t;
    typedef logic signed [AXIS_W-1:0]  axis_t;
    typedef logic signed [SCORE_W-1:0] score_t;
    typedef logic [POS_W-1:0]          pos_t;
    typedef logic [NUM_POS-1:0]        mask_t;

    typedef struct packed {
        score_t score;
        pos_t   pos;
    } cand_t;

    // Unit vectors scaled to radius 64, position 0 along +X, 30 degree steps CCW
    localparam axis_t DIR_X [NUM_POS] = '{
        8'sd64, 8'sd55, 8'sd32, 8'sd0, -8'sd32, -8'sd55,
        -8'sd64, -8'sd55, -8'sd32, 8'sd0, 8'sd32, 8'sd55
    };
    localparam axis_t DIR_Y [NUM_POS] = '{
        8'sd0, 8'sd32, 8'sd55, 8'sd64, 8'sd55, 8'sd32,
        8'sd0, -8'sd32, -8'sd55, -8'sd64, -8'sd55, -8'sd32
    };

    localparam pos_t LED_OFFSET = 4'd3;
    localparam pos_t LED_WRAP   = 4'd15;   // 3 + 12

    // Truncating divide by 256
    function automatic axis_t scale_axis(input sample_t v);
        sample_t adj;
        begin
            adj = v[IN_W-1] ? sample_t'(v + sample_t'(255)) : v;
            return axis_t'(adj >>> 8);
        end
    endfunction

    // Higher index wins only when strictly greater, so ties keep the lower one
    function automatic cand_t pick(input cand_t lo, input cand_t hi);
        begin
            return (hi.score > lo.score) ? hi : lo;
        end
    endfunction

    function automatic pos_t ring_led_of(input pos_t p);
        begin
            return (p <= LED_OFFSET) ? pos_t'(LED_OFFSET - p) : pos_t'(LED_WRAP - p);
        end
    endfunction

endpackage

@@ hdl/tilt_direction_to_clock_position_unit.sv @@
`timescale 1ns / 1ps
// Channel   Signals                                        Handshake
// input     accel_x, accel_y                               start && !busy
// result    clock_position, ring_led, led_onehot,          valid (one-cycle strobe)
//           best_score, no_positive_score
//
// Five-stage pipeline: scale, twelve constant-coefficient dot products,
// two compare levels within groups of four, final compare, LED decode.
// One transaction per cycle.
// busy is held low: the result side never stalls, so nothing backs up.
// rst_n clears the stage valid bits only.
module tilt_direction_to_clock_position_unit (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  tdcp_pkg::sample_t      accel_x,
    input  tdcp_pkg::sample_t      accel_y,
    output logic                   valid,
    output tdcp_pkg::pos_t         clock_position,
    output tdcp_pkg::pos_t         ring_led,
    output tdcp_pkg::mask_t        led_onehot,
    output logic [tdcp_pkg::BEST_W-1:0] best_score,
    output logic                   no_positive_score
);
    import tdcp_pkg::*;

    logic  [4:0] vld_reg;
    axis_t       sx_reg, sy_reg;
    score_t      score_reg [NUM_POS];
    cand_t       grp_reg   [NUM_GRP];
    cand_t       grp_next  [NUM_GRP];
    cand_t       win_reg;
    cand_t       win_next;
    logic        nopos_reg;
    pos_t        pos_out_reg;
    pos_t        led_reg;
    mask_t       mask_reg;
    logic [BEST_W-1:0] best_reg;
    logic        nopos_out_reg;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[3:0], start & ~busy};
        end
    end

    always_comb
    begin
        cand_t a, b;
        for (int g = 0; g < NUM_GRP; g++)
        begin
            a.score = score_reg[g*GROUP_SZ];
            a.pos   = pos_t'(g*GROUP_SZ);
            b.score = score_reg[g*GROUP_SZ+1];
            b.pos   = pos_t'(g*GROUP_SZ+1);
            a = pick(a, b);
            b.score = score_reg[g*GROUP_SZ+2];
            b.pos   = pos_t'(g*GROUP_SZ+2);
            begin
                cand_t c;
                c.score = score_reg[g*GROUP_SZ+3];
                c.pos   = pos_t'(g*GROUP_SZ+3);
                b = pick(b, c);
            end
            grp_next[g] = pick(a, b);
        end
    end

    always_comb
    begin
        win_next = grp_reg[0];
        for (int g = 1; g < NUM_GRP; g++)
        begin
            win_next = pick(win_next, grp_reg[g]);
        end
    end

    always_ff @(posedge clk)
    begin
        sx_reg <= scale_axis(accel_x);
        sy_reg <= scale_axis(accel_y);

        for (int i = 0; i < NUM_POS; i++)
        begin
            score_reg[i] <= score_t'(score_t'(sx_reg) * score_t'(DIR_X[i]))
                          + score_t'(score_t'(sy_reg) * score_t'(DIR_Y[i]));
        end

        for (int g = 0; g < NUM_GRP; g++)
        begin
            grp_reg[g] <= grp_next[g];
        end

        // no positive score falls back to position 0, score 0
        if (win_next.score > score_t'(0))
        begin
            win_reg   <= win_next;
            nopos_reg <= 1'b0;
        end
        else
        begin
            win_reg   <= '0;
            nopos_reg <= 1'b1;
        end

        pos_out_reg   <= win_reg.pos;
        led_reg       <= ring_led_of(win_reg.pos);
        mask_reg      <= mask_t'(1) << ring_led_of(win_reg.pos);
        best_reg      <= win_reg.score[BEST_W-1:0];
        nopos_out_reg <= nopos_reg;
    end

    assign valid             = vld_reg[4];
    assign clock_position    = pos_out_reg;
    assign ring_led          = led_reg;
    assign led_onehot        = mask_reg;
    assign best_score        = best_reg;
    assign no_positive_score = nopos_out_reg;

endmodule
